// ===== src/qrp_pkg.sv =====
// Shared types, constants and trig tables for the quad rotation block.
// Depends on nothing; every other source file imports it.
package qrp_pkg;

   // Default field widths
   localparam int COORD_WIDTH_DEF = 24;
   localparam int TRIG_FRAC_DEF   = 16;
   localparam int ANGLE_WIDTH     = 16;

   // Angle units: 1/64 degree
   localparam int FULL_TURN     = 23040;
   localparam int THREE_QUARTER = 17280;
   localparam int HALF_TURN     = 11520;
   localparam int QUARTER_TURN  = 5760;
   localparam int EIGHTH_TURN   = 2880;

   localparam int MOD_WIDTH  = 15;   // holds 0 .. FULL_TURN-1
   localparam int QTR_WIDTH  = 13;   // holds 0 .. QUARTER_TURN-1
   localparam int FOLD_WIDTH = 12;   // holds 0 .. EIGHTH_TURN
   localparam int IDX_WIDTH  = 6;
   localparam int TAB_N      = 1 << IDX_WIDTH;

   // Trig tables hold unsigned Q58 values in [0, 1]
   localparam int TBL_FRAC = 58;
   localparam int TBL_W    = TBL_FRAC + 1;
   localparam int SPLIT    = 30;
   localparam int PP_W     = 2 * SPLIT;
   localparam int PROD_W   = 2 * TBL_W;

   // Pipeline stages, in order
   localparam int ST_WRAP    = 0;
   localparam int ST_FOLD    = 1;
   localparam int ST_LOOK    = 2;
   localparam int ST_PART    = 3;
   localparam int ST_PROD    = 4;
   localparam int ST_SUM     = 5;
   localparam int ST_TRIG    = 6;
   localparam int ST_MUL     = 7;
   localparam int ST_DOT     = 8;
   localparam int ST_OUT     = 9;
   localparam int NUM_STAGES = 10;

   // Per-stage load strobes from the pipeline control
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } qrp_adv_type;

   typedef logic [TBL_W-1:0] tab_type [TAB_N];

   localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_STEP = PI_Q60 / 64'(HALF_TURN);

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      begin
         p = a * b;
         return p[123:60];
      end
   endfunction

   // Taylor series of sine and cosine at t/64 degree, Q60; returns {sin, cos}
   function automatic logic [127:0] series_q60(input logic [63:0] t);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] ss;
      logic [63:0] sc;
      begin
         x  = t * PI_STEP;
         x2 = mul_q60(x, x);
         ts = x;
         ss = x;
         tc = 64'd1 << 60;
         sc = 64'd1 << 60;
         ts = mul_q60(ts, x2) / 64'd6;   tc = mul_q60(tc, x2) / 64'd2;   ss -= ts; sc -= tc;
         ts = mul_q60(ts, x2) / 64'd20;  tc = mul_q60(tc, x2) / 64'd12;  ss += ts; sc += tc;
         ts = mul_q60(ts, x2) / 64'd42;  tc = mul_q60(tc, x2) / 64'd30;  ss -= ts; sc -= tc;
         ts = mul_q60(ts, x2) / 64'd72;  tc = mul_q60(tc, x2) / 64'd56;  ss += ts; sc += tc;
         ts = mul_q60(ts, x2) / 64'd110; tc = mul_q60(tc, x2) / 64'd90;  ss -= ts; sc -= tc;
         ts = mul_q60(ts, x2) / 64'd156; tc = mul_q60(tc, x2) / 64'd132; ss += ts; sc += tc;
         ts = mul_q60(ts, x2) / 64'd210; tc = mul_q60(tc, x2) / 64'd182; ss -= ts; sc -= tc;
         ts = mul_q60(ts, x2) / 64'd272; tc = mul_q60(tc, x2) / 64'd240; ss += ts; sc += tc;
         ts = mul_q60(ts, x2) / 64'd342; tc = mul_q60(tc, x2) / 64'd306; ss -= ts; sc -= tc;
         ts = mul_q60(ts, x2) / 64'd420; tc = mul_q60(tc, x2) / 64'd380; ss += ts; sc += tc;
         ts = mul_q60(ts, x2) / 64'd506; tc = mul_q60(tc, x2) / 64'd462; ss -= ts; sc -= tc;
         ts = mul_q60(ts, x2) / 64'd600; tc = mul_q60(tc, x2) / 64'd552; ss += ts; sc += tc;
         return {ss, sc};
      end
   endfunction

   // Build a Q58 table of sine or cosine at i*step/64 degree
   function automatic tab_type make_tab(input int step, input logic pick_cos);
      tab_type      tab;
      logic [127:0] sc;
      begin
         for (int i = 0; i < TAB_N; i++) begin
            sc     = series_q60(64'(i * step));
            tab[i] = pick_cos ? sc[60:2] : sc[124:66];
         end
         return tab;
      end
   endfunction

   // Coarse tables step by 64 units, fine tables by one unit
   localparam tab_type SIN_COARSE = make_tab(TAB_N, 1'b0);
   localparam tab_type COS_COARSE = make_tab(TAB_N, 1'b1);
   localparam tab_type SIN_FINE   = make_tab(1, 1'b0);
   localparam tab_type COS_FINE   = make_tab(1, 1'b1);

endpackage

// ===== src/qrp_chan_if.sv =====
// Request and response channel interfaces of the quad rotation block.
// Depends on qrp_pkg for the default widths.
interface qrp_req_if import qrp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] angle;
   logic signed [COORD_WIDTH-1:0] pivot_x;
   logic signed [COORD_WIDTH-1:0] pivot_y;
   logic signed [COORD_WIDTH-1:0] corner0_x;
   logic signed [COORD_WIDTH-1:0] corner0_y;
   logic signed [COORD_WIDTH-1:0] corner1_x;
   logic signed [COORD_WIDTH-1:0] corner1_y;
   logic signed [COORD_WIDTH-1:0] corner2_x;
   logic signed [COORD_WIDTH-1:0] corner2_y;
   logic signed [COORD_WIDTH-1:0] corner3_x;
   logic signed [COORD_WIDTH-1:0] corner3_y;

   modport source (
      output valid, angle, pivot_x, pivot_y,
      output corner0_x, corner0_y, corner1_x, corner1_y,
      output corner2_x, corner2_y, corner3_x, corner3_y,
      input  ready
   );
   modport sink (
      input  valid, angle, pivot_x, pivot_y,
      input  corner0_x, corner0_y, corner1_x, corner1_y,
      input  corner2_x, corner2_y, corner3_x, corner3_y,
      output ready
   );
endinterface

interface qrp_rsp_if import qrp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rotated0_x;
   logic signed [COORD_WIDTH-1:0] rotated0_y;
   logic signed [COORD_WIDTH-1:0] rotated1_x;
   logic signed [COORD_WIDTH-1:0] rotated1_y;
   logic signed [COORD_WIDTH-1:0] rotated2_x;
   logic signed [COORD_WIDTH-1:0] rotated2_y;
   logic signed [COORD_WIDTH-1:0] rotated3_x;
   logic signed [COORD_WIDTH-1:0] rotated3_y;

   modport source (
      output valid, rotated0_x, rotated0_y, rotated1_x, rotated1_y,
      output rotated2_x, rotated2_y, rotated3_x, rotated3_y,
      input  ready
   );
   modport sink (
      input  valid, rotated0_x, rotated0_y, rotated1_x, rotated1_y,
      input  rotated2_x, rotated2_y, rotated3_x, rotated3_y,
      output ready
   );
endinterface

// ===== src/quad_rotate_about_pivot_top.sv =====
// Top level of the quad rotation block: pipeline control, offsets, trig and corners.
// Depends on qrp_pkg, qrp_chan_if.sv, qrp_sincos and qrp_corner.
//
//   channel    | dir | handshake     | carries
//   -----------+-----+---------------+-------------------------------------------
//   req_chan   | in  | valid / ready | angle, pivot_x/y, corner0..3_x/y
//   rsp_chan   | out | valid / ready | rotated0..3_x/y
//
// One quad per cycle sustained while rsp_chan is ready; a transfer passes through
// the ten register stages (angle wrap, fold, table read, split products, product
// sums, identity sums, round, corner multiply, corner round, pivot add and clamp)
// before it reaches rsp_chan.
// Reset is synchronous and clears only the stage valid bits.
// A stalled result holds in the output stage; earlier stages keep advancing
// into empty slots, so bubbles close up and nothing is lost or repeated.
module quad_rotate_about_pivot_top import qrp_pkg::*; #(
   parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
   input  logic     clock,
   input  logic     reset,
   qrp_req_if.sink  req_chan,
   qrp_rsp_if.source rsp_chan
);

   localparam int DW     = COORD_WIDTH + 1;
   localparam int TW     = TRIG_FRAC_BITS + 2;
   localparam int GEO_W  = 2 * COORD_WIDTH + 8 * DW;
   localparam int PIV_LO = 8 * DW;

   // ---------------------------------------------------------------------
   // Stage control: a stage takes new content when it is empty or when the
   // stage after it moves on. Load only when a valid item arrives.
   // ---------------------------------------------------------------------
   logic [NUM_STAGES:0]   rdy;
   logic [NUM_STAGES-1:0] up_vld;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] vld_ff;
   qrp_adv_type           adv;

   assign rdy[NUM_STAGES] = rsp_chan.ready;
   assign up_vld          = {vld_ff[NUM_STAGES-2:0], req_chan.valid};

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_ctl
      assign rdy[s]       = !vld_ff[s] || rdy[s+1];
      assign vld_in[s]    = rdy[s] ? up_vld[s] : vld_ff[s];
      assign adv.load[s]  = rdy[s] && up_vld[s];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = rdy[0];
   assign rsp_chan.valid = vld_ff[ST_OUT];

   // ---------------------------------------------------------------------
   // Offsets from the pivot, one bit wider than a coordinate so they never
   // wrap. Pack them with the pivot and carry them alongside the trig stages.
   // ---------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] cx [4];
   logic signed [COORD_WIDTH-1:0] cy [4];
   logic signed [DW-1:0]          dx [4];
   logic signed [DW-1:0]          dy [4];
   logic [GEO_W-1:0]              geo_in;
   logic [GEO_W-1:0]              geo_ff [ST_TRIG+1];

   assign cx[0] = req_chan.corner0_x;
   assign cy[0] = req_chan.corner0_y;
   assign cx[1] = req_chan.corner1_x;
   assign cy[1] = req_chan.corner1_y;
   assign cx[2] = req_chan.corner2_x;
   assign cy[2] = req_chan.corner2_y;
   assign cx[3] = req_chan.corner3_x;
   assign cy[3] = req_chan.corner3_y;

   for (genvar k = 0; k < 4; k++) begin : g_off
      assign dx[k] = DW'(cx[k]) - DW'(req_chan.pivot_x);
      assign dy[k] = DW'(cy[k]) - DW'(req_chan.pivot_y);
      assign geo_in[(2*k)*DW +: DW]   = dx[k];
      assign geo_in[(2*k+1)*DW +: DW] = dy[k];
   end

   assign geo_in[PIV_LO +: COORD_WIDTH]               = req_chan.pivot_y;
   assign geo_in[PIV_LO + COORD_WIDTH +: COORD_WIDTH] = req_chan.pivot_x;

   always_ff @(posedge clock) begin
      if (adv.load[ST_WRAP]) begin
         geo_ff[ST_WRAP] <= geo_in;
      end
   end

   // Hold the geometry in step with the trig pipeline
   for (genvar s = ST_FOLD; s <= ST_TRIG; s++) begin : g_geo
      always_ff @(posedge clock) begin
         if (adv.load[s]) begin
            geo_ff[s] <= geo_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sine and cosine, valid at the trig stage
   // ---------------------------------------------------------------------
   logic signed [TW-1:0] sin_v;
   logic signed [TW-1:0] cos_v;

   qrp_sincos #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_sincos (
      .clock   (clock),
      .adv     (adv),
      .angle   (req_chan.angle),
      .sin_out (sin_v),
      .cos_out (cos_v)
   );

   // ---------------------------------------------------------------------
   // Four corner units; their last stage is the output register
   // ---------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] rot_x [4];
   logic signed [COORD_WIDTH-1:0] rot_y [4];

   for (genvar k = 0; k < 4; k++) begin : g_corner
      qrp_corner #(
         .COORD_WIDTH    (COORD_WIDTH),
         .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
      ) u_corner (
         .clock   (clock),
         .adv     (adv),
         .dx      (geo_ff[ST_TRIG][(2*k)*DW +: DW]),
         .dy      (geo_ff[ST_TRIG][(2*k+1)*DW +: DW]),
         .pivot_x (geo_ff[ST_TRIG][PIV_LO + COORD_WIDTH +: COORD_WIDTH]),
         .pivot_y (geo_ff[ST_TRIG][PIV_LO +: COORD_WIDTH]),
         .sin_in  (sin_v),
         .cos_in  (cos_v),
         .rot_x   (rot_x[k]),
         .rot_y   (rot_y[k])
      );
   end

   assign rsp_chan.rotated0_x = rot_x[0];
   assign rsp_chan.rotated0_y = rot_y[0];
   assign rsp_chan.rotated1_x = rot_x[1];
   assign rsp_chan.rotated1_y = rot_y[1];
   assign rsp_chan.rotated2_x = rot_x[2];
   assign rsp_chan.rotated2_y = rot_y[2];
   assign rsp_chan.rotated3_x = rot_x[3];
   assign rsp_chan.rotated3_y = rot_y[3];

endmodule

// ===== src/qrp_sincos.sv =====
// Pipelined sine/cosine of an angle in 1/64 degree, rounded to TRIG_FRAC_BITS.
// Depends on qrp_pkg for tables, stage indices and the load strobes.
module qrp_sincos import qrp_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
   input  logic                            clock,
   input  qrp_adv_type                     adv,
   input  logic signed [ANGLE_WIDTH-1:0]   angle,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_out,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_out
);

   localparam int TW       = TRIG_FRAC_BITS + 2;
   localparam int MW       = TRIG_FRAC_BITS + 1;
   localparam int ROUND_SH = 2 * TBL_FRAC - TRIG_FRAC_BITS;
   localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (ROUND_SH - 1);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic signed [ANGLE_WIDTH:0] TURN_S = (ANGLE_WIDTH+1)'(FULL_TURN);

   // wrap: reduce to one turn
   logic signed [ANGLE_WIDTH:0] ang_ext;
   logic signed [ANGLE_WIDTH:0] ang_off;
   logic signed [ANGLE_WIDTH:0] ang_sum;
   logic [MOD_WIDTH-1:0]        mod_ff;

   always_comb begin
      ang_ext = (ANGLE_WIDTH+1)'(angle);
      if (ang_ext < -TURN_S) begin
         ang_off = TURN_S + TURN_S;
      end else if (ang_ext < 0) begin
         ang_off = TURN_S;
      end else if (ang_ext >= TURN_S) begin
         ang_off = -TURN_S;
      end else begin
         ang_off = '0;
      end
      ang_sum = ang_ext + ang_off;
   end

   always_ff @(posedge clock) begin
      if (adv.load[ST_WRAP]) begin
         mod_ff <= ang_sum[MOD_WIDTH-1:0];
      end
   end

   // fold: quadrant, then mirror into the first eighth
   logic [1:0]            quad_in;
   logic [MOD_WIDTH-1:0]  quad_base;
   logic [QTR_WIDTH-1:0]  rem;
   logic [QTR_WIDTH-1:0]  fold;
   logic                  swap_in;
   logic [2:0]            ctl_fold_ff;
   logic [IDX_WIDTH-1:0]  hi_ff;
   logic [IDX_WIDTH-1:0]  lo_ff;

   always_comb begin
      if (mod_ff < MOD_WIDTH'(QUARTER_TURN)) begin
         quad_in   = QUAD_0;
         quad_base = '0;
      end else if (mod_ff < MOD_WIDTH'(HALF_TURN)) begin
         quad_in   = QUAD_1;
         quad_base = MOD_WIDTH'(QUARTER_TURN);
      end else if (mod_ff < MOD_WIDTH'(THREE_QUARTER)) begin
         quad_in   = QUAD_2;
         quad_base = MOD_WIDTH'(HALF_TURN);
      end else begin
         quad_in   = QUAD_3;
         quad_base = MOD_WIDTH'(THREE_QUARTER);
      end
      rem     = QTR_WIDTH'(mod_ff - quad_base);
      swap_in = rem > QTR_WIDTH'(EIGHTH_TURN);
      fold    = swap_in ? QTR_WIDTH'(QUARTER_TURN) - rem : rem;
   end

   always_ff @(posedge clock) begin
      if (adv.load[ST_FOLD]) begin
         ctl_fold_ff <= {swap_in, quad_in};
         hi_ff       <= fold[FOLD_WIDTH-1:IDX_WIDTH];
         lo_ff       <= fold[IDX_WIDTH-1:0];
      end
   end

   // look: coarse and fine table reads
   logic [TBL_W-1:0] sa_ff;
   logic [TBL_W-1:0] ca_ff;
   logic [TBL_W-1:0] sb_ff;
   logic [TBL_W-1:0] cb_ff;
   logic [2:0]       ctl_look_ff;

   always_ff @(posedge clock) begin
      if (adv.load[ST_LOOK]) begin
         sa_ff       <= SIN_COARSE[hi_ff];
         ca_ff       <= COS_COARSE[hi_ff];
         sb_ff       <= SIN_FINE[lo_ff];
         cb_ff       <= COS_FINE[lo_ff];
         ctl_look_ff <= ctl_fold_ff;
      end
   end

   // part: split each of the four products into four partials, operands cut at bit 30
   logic [TBL_W-1:0] opa [4];
   logic [TBL_W-1:0] opb [4];
   logic [PP_W-1:0]  pp_hh_ff [4];
   logic [PP_W-1:0]  pp_hl_ff [4];
   logic [PP_W-1:0]  pp_lh_ff [4];
   logic [PP_W-1:0]  pp_ll_ff [4];
   logic [PROD_W-1:0] prod_ff [4];
   logic [2:0]       ctl_part_ff;
   logic [2:0]       ctl_prod_ff;

   assign opa[0] = sa_ff;
   assign opb[0] = cb_ff;
   assign opa[1] = ca_ff;
   assign opb[1] = sb_ff;
   assign opa[2] = ca_ff;
   assign opb[2] = cb_ff;
   assign opa[3] = sa_ff;
   assign opb[3] = sb_ff;

   for (genvar g = 0; g < 4; g++) begin : g_prod
      always_ff @(posedge clock) begin
         if (adv.load[ST_PART]) begin
            pp_hh_ff[g] <= PP_W'(opa[g][TBL_W-1:SPLIT]) * PP_W'(opb[g][TBL_W-1:SPLIT]);
            pp_hl_ff[g] <= PP_W'(opa[g][TBL_W-1:SPLIT]) * PP_W'(opb[g][SPLIT-1:0]);
            pp_lh_ff[g] <= PP_W'(opa[g][SPLIT-1:0]) * PP_W'(opb[g][TBL_W-1:SPLIT]);
            pp_ll_ff[g] <= PP_W'(opa[g][SPLIT-1:0]) * PP_W'(opb[g][SPLIT-1:0]);
         end
      end

      always_ff @(posedge clock) begin
         if (adv.load[ST_PROD]) begin
            prod_ff[g] <= (PROD_W'(pp_hh_ff[g]) << (2 * SPLIT))
                        + (PROD_W'(pp_hl_ff[g]) << SPLIT)
                        + (PROD_W'(pp_lh_ff[g]) << SPLIT)
                        + PROD_W'(pp_ll_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.load[ST_PART]) begin
         ctl_part_ff <= ctl_look_ff;
      end
      if (adv.load[ST_PROD]) begin
         ctl_prod_ff <= ctl_part_ff;
      end
   end

   // sum: angle-addition identities
   logic [PROD_W-1:0] sum_s_ff;
   logic [PROD_W-1:0] sum_c_ff;
   logic [2:0]        ctl_sum_ff;

   always_ff @(posedge clock) begin
      if (adv.load[ST_SUM]) begin
         sum_s_ff   <= prod_ff[0] + prod_ff[1];
         sum_c_ff   <= prod_ff[2] - prod_ff[3];
         ctl_sum_ff <= ctl_prod_ff;
      end
   end

   // trig: round, undo the mirror, apply quadrant signs
   logic [PROD_W-1:0]    rnd_s;
   logic [PROD_W-1:0]    rnd_c;
   logic [MW-1:0]        mag_s;
   logic [MW-1:0]        mag_c;
   logic signed [TW-1:0] pos_s;
   logic signed [TW-1:0] pos_c;
   logic signed [TW-1:0] sn_in;
   logic signed [TW-1:0] cs_in;
   logic signed [TW-1:0] sn_ff;
   logic signed [TW-1:0] cs_ff;

   always_comb begin
      rnd_s = sum_s_ff + RND;
      rnd_c = sum_c_ff + RND;
      mag_s = rnd_s[ROUND_SH +: MW];
      mag_c = rnd_c[ROUND_SH +: MW];
      pos_s = ctl_sum_ff[2] ? {1'b0, mag_c} : {1'b0, mag_s};
      pos_c = ctl_sum_ff[2] ? {1'b0, mag_s} : {1'b0, mag_c};
      case (ctl_sum_ff[1:0])
         QUAD_0: begin
            sn_in = pos_s;
            cs_in = pos_c;
         end
         QUAD_1: begin
            sn_in = pos_c;
            cs_in = -pos_s;
         end
         QUAD_2: begin
            sn_in = -pos_s;
            cs_in = -pos_c;
         end
         default: begin
            sn_in = -pos_c;
            cs_in = pos_s;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.load[ST_TRIG]) begin
         sn_ff <= sn_in;
         cs_ff <= cs_in;
      end
   end

   assign sin_out = sn_ff;
   assign cos_out = cs_ff;

endmodule

// ===== src/qrp_corner.sv =====
// One corner's rotation: multiply, round, add pivot and saturate.
// Depends on qrp_pkg for stage indices and the load strobes.
module qrp_corner import qrp_pkg::*; #(
   parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
   input  logic                             clock,
   input  qrp_adv_type                      adv,
   input  logic signed [COORD_WIDTH:0]      dx,
   input  logic signed [COORD_WIDTH:0]      dy,
   input  logic signed [COORD_WIDTH-1:0]    pivot_x,
   input  logic signed [COORD_WIDTH-1:0]    pivot_y,
   input  logic signed [TRIG_FRAC_BITS+1:0] sin_in,
   input  logic signed [TRIG_FRAC_BITS+1:0] cos_in,
   output logic signed [COORD_WIDTH-1:0]    rot_x,
   output logic signed [COORD_WIDTH-1:0]    rot_y
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int MW = DW + TW;
   localparam int SW = MW + 1;
   localparam int RW = COORD_WIDTH + 4;
   localparam int OW = COORD_WIDTH + 5;

   localparam logic signed [SW-1:0] RND_HALF = SW'(64'd1 << (TRIG_FRAC_BITS - 1));
   localparam logic signed [OW-1:0] SAT_MAX  = OW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic signed [OW-1:0] SAT_MIN  = -SAT_MAX - OW'(1);

   // mul
   logic signed [MW-1:0]          dxc_ff;
   logic signed [MW-1:0]          dys_ff;
   logic signed [MW-1:0]          dxs_ff;
   logic signed [MW-1:0]          dyc_ff;
   logic signed [COORD_WIDTH-1:0] px_m_ff;
   logic signed [COORD_WIDTH-1:0] py_m_ff;

   always_ff @(posedge clock) begin
      if (adv.load[ST_MUL]) begin
         dxc_ff  <= MW'(dx) * MW'(cos_in);
         dys_ff  <= MW'(dy) * MW'(sin_in);
         dxs_ff  <= MW'(dx) * MW'(sin_in);
         dyc_ff  <= MW'(dy) * MW'(cos_in);
         px_m_ff <= pivot_x;
         py_m_ff <= pivot_y;
      end
   end

   // dot: sum the pair and round to nearest, ties up
   logic signed [SW-1:0]          sum_x;
   logic signed [SW-1:0]          sum_y;
   logic signed [RW-1:0]          dot_x_ff;
   logic signed [RW-1:0]          dot_y_ff;
   logic signed [COORD_WIDTH-1:0] px_d_ff;
   logic signed [COORD_WIDTH-1:0] py_d_ff;

   assign sum_x = SW'(dxc_ff) - SW'(dys_ff) + RND_HALF;
   assign sum_y = SW'(dxs_ff) + SW'(dyc_ff) + RND_HALF;

   always_ff @(posedge clock) begin
      if (adv.load[ST_DOT]) begin
         dot_x_ff <= sum_x[TRIG_FRAC_BITS +: RW];
         dot_y_ff <= sum_y[TRIG_FRAC_BITS +: RW];
         px_d_ff  <= px_m_ff;
         py_d_ff  <= py_m_ff;
      end
   end

   // out: add pivot and clamp
   logic signed [OW-1:0]          full_x;
   logic signed [OW-1:0]          full_y;
   logic signed [COORD_WIDTH-1:0] sat_x;
   logic signed [COORD_WIDTH-1:0] sat_y;
   logic signed [COORD_WIDTH-1:0] rot_x_ff;
   logic signed [COORD_WIDTH-1:0] rot_y_ff;

   always_comb begin
      full_x = OW'(px_d_ff) + OW'(dot_x_ff);
      full_y = OW'(py_d_ff) + OW'(dot_y_ff);
      if (full_x > SAT_MAX) begin
         sat_x = SAT_MAX[COORD_WIDTH-1:0];
      end else if (full_x < SAT_MIN) begin
         sat_x = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
         sat_x = full_x[COORD_WIDTH-1:0];
      end
      if (full_y > SAT_MAX) begin
         sat_y = SAT_MAX[COORD_WIDTH-1:0];
      end else if (full_y < SAT_MIN) begin
         sat_y = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
         sat_y = full_y[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.load[ST_OUT]) begin
         rot_x_ff <= sat_x;
         rot_y_ff <= sat_y;
      end
   end

   assign rot_x = rot_x_ff;
   assign rot_y = rot_y_ff;

endmodule

// ===== tb/quad_rotate_about_pivot_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quad_rotate_about_pivot_top: random and directed quads in, rotated corners out.
// Depends on qrp_pkg, the qrp_req_if / qrp_rsp_if interfaces and the block itself.
module quad_rotate_about_pivot_top_tb;
   import qrp_pkg::*;

   localparam int     CW            = COORD_WIDTH_DEF;
   localparam int     TRIG_SHIFT    = 60 - TRIG_FRAC_DEF;
   localparam int     SERIES_TERMS  = 12;
   localparam int     RANDOM_QUADS  = 1600;
   localparam int     IDLE_PCT      = 7;
   localparam int     QUIET_FROM    = 700;
   localparam int     QUIET_TO      = 1000;
   localparam int     HOLDOFF_FIRST = 300;
   localparam int     HOLDOFF_EVERY = 1000;
   localparam int     HOLDOFF_LEN   = 80;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     CYCLE_LIMIT   = 200000;
   localparam longint COORD_MAX     = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint COORD_MIN     = -COORD_MAX - 1;
   localparam logic [63:0] ONE_Q60      = 64'd1 << 60;
   localparam logic [63:0] RAD_PER_UNIT = PI_Q60 / 64'(HALF_TURN);

   // Which quarter of the turn the wrapped angle falls in
   typedef enum int {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quarter_t;

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0] angle;
      logic [CW-1:0]          pivot_x;
      logic [CW-1:0]          pivot_y;
      logic [3:0][CW-1:0]     x;
      logic [3:0][CW-1:0]     y;
   } quad_req_t;

   typedef struct packed {
      logic [3:0][CW-1:0] x;
      logic [3:0][CW-1:0] y;
   } quad_pts_t;

   logic clock = 1'b0;
   logic reset;

   qrp_req_if #(.COORD_WIDTH(CW)) req_chan ();
   qrp_rsp_if #(.COORD_WIDTH(CW)) rsp_chan ();

   quad_rotate_about_pivot_top #(
      .COORD_WIDTH   (CW),
      .TRIG_FRAC_BITS(TRIG_FRAC_DEF)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   quad_req_t pending_quads [$];   // stimulus not yet put on the request channel
   quad_pts_t rotated_due [$];     // expected corners, oldest first
   quad_pts_t seen_pts;
   quad_pts_t due_pts;
   int        error_count   = 0;
   int        quads_sent    = 0;
   int        cycle_count   = 0;
   int        results_seen  = 0;
   int        holdoff_left  = 0;
   int        next_holdoff  = HOLDOFF_FIRST;
   logic      quiet_stretch = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: sine and cosine from a Q60 Taylor series, rounded to the trig
   // precision, then each corner's offset rotated and rounded once per axis.
   // ---------------------------------------------------------------------------
   function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[123:60];
   endfunction

   // Sine and cosine of t/64 degree for t in 0 .. eighth turn, unsigned Q60
   function automatic void sin_cos_q60(input logic [63:0] t, output logic [63:0] s,
                                       output logic [63:0] c);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term_s;
      logic [63:0] term_c;
      logic [63:0] n;
      x      = t * RAD_PER_UNIT;
      x2     = q60_product(x, x);
      term_s = x;
      term_c = ONE_Q60;
      s      = x;
      c      = ONE_Q60;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         n      = 64'(2 * k);
         term_s = q60_product(term_s, x2) / (n * (n + 64'd1));
         term_c = q60_product(term_c, x2) / ((n - 64'd1) * n);
         if (k % 2 == 1) begin
            s = s - term_s;
            c = c - term_c;
         end else begin
            s = s + term_s;
            c = c + term_c;
         end
      end
   endfunction

   function automatic longint trig_to_fixed(input logic [63:0] v);
      return longint'((v + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT);
   endfunction

   // Sum of two products, rounded to nearest with ties upward
   function automatic longint scaled_dot(input longint p, input longint cp,
                                         input longint q, input longint cq);
      return (p * cp + q * cq + (longint'(1) <<< (TRIG_FRAC_DEF - 1))) >>> TRIG_FRAC_DEF;
   endfunction

   function automatic logic [CW-1:0] clamp_coord(input longint v);
      longint c;
      c = v;
      if (c > COORD_MAX) c = COORD_MAX;
      if (c < COORD_MIN) c = COORD_MIN;
      return c[CW-1:0];
   endfunction

   function automatic quad_pts_t rotate_quad(input quad_req_t q);
      quad_pts_t   pts;
      int          wrapped;
      int          rem;
      quarter_t    quarter;
      logic [63:0] s_q60;
      logic [63:0] c_q60;
      longint      s0;
      longint      c0;
      longint      sn;
      longint      cs;
      longint      px;
      longint      py;
      longint      dx;
      longint      dy;
      // Wrap into one turn, then fold onto the first eighth
      wrapped = ((int'($signed(q.angle)) % FULL_TURN) + FULL_TURN) % FULL_TURN;
      quarter = quarter_t'(wrapped / QUARTER_TURN);
      rem     = wrapped % QUARTER_TURN;
      if (rem <= EIGHTH_TURN) begin
         sin_cos_q60(64'(rem), s_q60, c_q60);
         s0 = trig_to_fixed(s_q60);
         c0 = trig_to_fixed(c_q60);
      end else begin
         sin_cos_q60(64'(QUARTER_TURN - rem), s_q60, c_q60);
         s0 = trig_to_fixed(c_q60);
         c0 = trig_to_fixed(s_q60);
      end
      case (quarter)
         QUAD_I: begin
            sn = s0;
            cs = c0;
         end
         QUAD_II: begin
            sn = c0;
            cs = -s0;
         end
         QUAD_III: begin
            sn = -s0;
            cs = -c0;
         end
         default: begin
            sn = -c0;
            cs = s0;
         end
      endcase
      px = longint'($signed(q.pivot_x));
      py = longint'($signed(q.pivot_y));
      for (int i = 0; i < 4; i++) begin
         dx = longint'($signed(q.x[i])) - px;
         dy = longint'($signed(q.y[i])) - py;
         pts.x[i] = clamp_coord(px + scaled_dot(dx, cs, dy, -sn));
         pts.y[i] = clamp_coord(py + scaled_dot(dx, sn, dy, cs));
      end
      return pts;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic longint spread(input int reach);
      return longint'($urandom_range(0, 2 * reach)) - longint'(reach);
   endfunction

   // Coordinates at or close to the ends of the range, or zero
   function automatic logic [CW-1:0] rim_coord();
      longint v;
      case ($urandom_range(0, 4))
         0:       v = COORD_MAX;
         1:       v = COORD_MIN;
         2:       v = COORD_MAX - longint'($urandom_range(0, 255));
         3:       v = COORD_MIN + longint'($urandom_range(0, 255));
         default: v = 0;
      endcase
      return v[CW-1:0];
   endfunction

   function automatic quad_req_t random_quad();
      quad_req_t q;
      int        ang;
      int        reach;
      longint    base_x;
      longint    base_y;
      longint    v;
      case ($urandom_range(0, 3))
         0:       ang = int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
         1:       ang = int'($urandom_range(0, 65535));
         2:       ang = EIGHTH_TURN * int'($urandom_range(0, 16)) - FULL_TURN
                        + int'($urandom_range(0, 4)) - 2;
         default: ang = int'($urandom_range(0, 128)) - 64;
      endcase
      q.angle = ang[ANGLE_WIDTH-1:0];
      case ($urandom_range(0, 9))
         0, 1: begin
            // Anywhere in the plane: large offsets, frequent saturation
            q.pivot_x = CW'($urandom());
            q.pivot_y = CW'($urandom());
            for (int i = 0; i < 4; i++) begin
               q.x[i] = CW'($urandom());
               q.y[i] = CW'($urandom());
            end
         end
         8: begin
            q.pivot_x = rim_coord();
            q.pivot_y = rim_coord();
            for (int i = 0; i < 4; i++) begin
               q.x[i] = rim_coord();
               q.y[i] = rim_coord();
            end
         end
         9: begin
            q.pivot_x = rim_coord();
            q.pivot_y = rim_coord();
            for (int i = 0; i < 4; i++) begin
               q.x[i] = CW'($urandom());
               q.y[i] = CW'($urandom());
            end
         end
         default: begin
            // Typical sprite: corners within a few bounds of the pivot
            reach  = 1 << $urandom_range(4, 18);
            base_x = spread(1 << 21);
            base_y = spread(1 << 21);
            q.pivot_x = base_x[CW-1:0];
            q.pivot_y = base_y[CW-1:0];
            for (int i = 0; i < 4; i++) begin
               v      = base_x + spread(reach);
               q.x[i] = v[CW-1:0];
               v      = base_y + spread(reach);
               q.y[i] = v[CW-1:0];
            end
            if ($urandom_range(0, 7) == 0) begin
               v         = longint'($urandom_range(0, 3));
               q.x[v] = q.pivot_x;
               q.y[v] = q.pivot_y;
            end
         end
      endcase
      return q;
   endfunction

   function automatic quad_req_t angled_quad(input int ang);
      quad_req_t q;
      q       = random_quad();
      q.angle = ang[ANGLE_WIDTH-1:0];
      return q;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------------
   // Request driver: hold the quad until it is taken, then offer the next one
   // unless this cycle idles. The expectation is queued as the quad goes on the
   // channel, so it is always waiting before its result can appear.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_quads.size() != 0
             && (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
            quad_req_t q;
            q = pending_quads.pop_front();
            rotated_due.push_back(rotate_quad(q));
            req_chan.angle     <= q.angle;
            req_chan.pivot_x   <= q.pivot_x;
            req_chan.pivot_y   <= q.pivot_y;
            req_chan.corner0_x <= q.x[0];
            req_chan.corner0_y <= q.y[0];
            req_chan.corner1_x <= q.x[1];
            req_chan.corner1_y <= q.y[1];
            req_chan.corner2_x <= q.x[2];
            req_chan.corner2_y <= q.y[2];
            req_chan.corner3_x <= q.x[3];
            req_chan.corner3_y <= q.y[3];
            req_chan.valid     <= 1'b1;
            quads_sent++;
            // One long stretch in the middle of the run with no idling on either side
            quiet_stretch <= (quads_sent >= QUIET_FROM && quads_sent < QUIET_TO);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response receiver: random back-pressure, plus long hold-offs at set points
   // so that the pipeline fills and the request side stalls.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) results_seen++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_chan.ready <= 1'b0;
         end else if (results_seen >= next_holdoff) begin
            holdoff_left = HOLDOFF_LEN;
            next_holdoff += HOLDOFF_EVERY;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: compare every response transfer with the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rotated_due.size() == 0) begin
            report_mismatch("response transfer with no quad outstanding");
         end else begin
            due_pts       = rotated_due.pop_front();
            seen_pts.x[0] = rsp_chan.rotated0_x;
            seen_pts.y[0] = rsp_chan.rotated0_y;
            seen_pts.x[1] = rsp_chan.rotated1_x;
            seen_pts.y[1] = rsp_chan.rotated1_y;
            seen_pts.x[2] = rsp_chan.rotated2_x;
            seen_pts.y[2] = rsp_chan.rotated2_y;
            seen_pts.x[3] = rsp_chan.rotated3_x;
            seen_pts.y[3] = rsp_chan.rotated3_y;
            for (int i = 0; i < 4; i++) begin
               if (seen_pts.x[i] !== due_pts.x[i])
                  report_mismatch($sformatf("rotated%0d_x got %0d want %0d", i,
                                  $signed(seen_pts.x[i]), $signed(due_pts.x[i])));
               if (seen_pts.y[i] !== due_pts.y[i])
                  report_mismatch($sformatf("rotated%0d_y got %0d want %0d", i,
                                  $signed(seen_pts.y[i]), $signed(due_pts.y[i])));
            end
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quad_rotate_about_pivot_top_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: initialise the inputs, queue directed then random quads, release
   // reset, drain, settle and report.
   // ---------------------------------------------------------------------------
   initial begin
      quad_req_t q;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.angle     = '0;
      req_chan.pivot_x   = '0;
      req_chan.pivot_y   = '0;
      req_chan.corner0_x = '0;
      req_chan.corner0_y = '0;
      req_chan.corner1_x = '0;
      req_chan.corner1_y = '0;
      req_chan.corner2_x = '0;
      req_chan.corner2_y = '0;
      req_chan.corner3_x = '0;
      req_chan.corner3_y = '0;
      rsp_chan.ready     = 1'b0;

      // Zero angle and whole turns: corners pass through unchanged
      pending_quads.push_back(angled_quad(0));
      pending_quads.push_back(angled_quad(FULL_TURN));
      pending_quads.push_back(angled_quad(-FULL_TURN));
      // Quarter turns, where sine or cosine is exactly plus or minus one
      pending_quads.push_back(angled_quad(QUARTER_TURN));
      pending_quads.push_back(angled_quad(HALF_TURN));
      pending_quads.push_back(angled_quad(THREE_QUARTER));
      pending_quads.push_back(angled_quad(-QUARTER_TURN));
      // Either side of the eighth-turn fold
      pending_quads.push_back(angled_quad(EIGHTH_TURN));
      pending_quads.push_back(angled_quad(EIGHTH_TURN + 1));
      pending_quads.push_back(angled_quad(EIGHTH_TURN - 1));
      pending_quads.push_back(angled_quad(QUARTER_TURN - 1));
      // Ends of the angle field, beyond a full turn, and bit patterns
      pending_quads.push_back(angled_quad(32767));
      pending_quads.push_back(angled_quad(-32768));
      pending_quads.push_back(angled_quad(int'(16'h5555)));
      pending_quads.push_back(angled_quad(-21846));
      pending_quads.push_back(angled_quad(-1));
      pending_quads.push_back(angled_quad(1));

      // Every corner on the pivot: nothing moves
      q = angled_quad(1000);
      for (int i = 0; i < 4; i++) begin
         q.x[i] = q.pivot_x;
         q.y[i] = q.pivot_y;
      end
      pending_quads.push_back(q);

      // Half turn across the full range: saturate high, then low
      q         = angled_quad(HALF_TURN);
      q.pivot_x = COORD_MAX[CW-1:0];
      q.pivot_y = COORD_MAX[CW-1:0];
      for (int i = 0; i < 4; i++) begin
         q.x[i] = COORD_MIN[CW-1:0];
         q.y[i] = COORD_MIN[CW-1:0];
      end
      pending_quads.push_back(q);
      q.pivot_x = COORD_MIN[CW-1:0];
      q.pivot_y = COORD_MIN[CW-1:0];
      for (int i = 0; i < 4; i++) begin
         q.x[i] = COORD_MAX[CW-1:0];
         q.y[i] = COORD_MAX[CW-1:0];
      end
      pending_quads.push_back(q);

      // All zero, then alternating bit patterns
      pending_quads.push_back('0);
      q         = angled_quad(int'(16'h5555));
      q.pivot_x = {(CW / 2){2'b01}};
      q.pivot_y = {(CW / 2){2'b10}};
      for (int i = 0; i < 4; i++) begin
         q.x[i] = {(CW / 2){2'b10}};
         q.y[i] = {(CW / 2){2'b01}};
      end
      pending_quads.push_back(q);

      for (int n = 0; n < RANDOM_QUADS; n++)
         pending_quads.push_back(random_quad());

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain: every quad offered and taken, every result back
      while (pending_quads.size() != 0 || req_chan.valid || rotated_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("quad_rotate_about_pivot_top_tb: clean");
      end else begin
         $display("quad_rotate_about_pivot_top_tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/qrp_pkg.sv
src/qrp_chan_if.sv
src/qrp_sincos.sv
src/qrp_corner.sv
src/quad_rotate_about_pivot_top.sv
tb/quad_rotate_about_pivot_top_tb.sv
